// ===== src/saabb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saabb_pkg
// shared defaults for the swept box collision pipeline
// ----------------------------------------------------------------------------
package saabb_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
endpackage
`default_nettype wire

// ===== src/saabb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saabb_front
// first stage: expanded slab edges minus point, and relative velocity
// ----------------------------------------------------------------------------
module saabb_front import saabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS-1:0] mover_x,
    input  wire logic signed [COORD_BITS-1:0] mover_y,
    input  wire logic        [COORD_BITS-2:0] mover_half_w,
    input  wire logic        [COORD_BITS-2:0] mover_half_h,
    input  wire logic signed [COORD_BITS-1:0] mover_vx,
    input  wire logic signed [COORD_BITS-1:0] mover_vy,
    input  wire logic signed [COORD_BITS-1:0] target_x,
    input  wire logic signed [COORD_BITS-1:0] target_y,
    input  wire logic        [COORD_BITS-2:0] target_half_w,
    input  wire logic        [COORD_BITS-2:0] target_half_h,
    input  wire logic signed [COORD_BITS-1:0] target_vx,
    input  wire logic signed [COORD_BITS-1:0] target_vy,
    output logic signed      [COORD_BITS+2:0] num_nx_reg,
    output logic signed      [COORD_BITS+2:0] num_fx_reg,
    output logic signed      [COORD_BITS+2:0] num_ny_reg,
    output logic signed      [COORD_BITS+2:0] num_fy_reg,
    output logic signed      [COORD_BITS:0]   den_x_reg,
    output logic signed      [COORD_BITS:0]   den_y_reg
);
    localparam int NW = COORD_BITS + 3;

    logic        [COORD_BITS-1:0] ew, eh;
    logic signed [NW-1:0]         ewe, ehe, dx, dy;

    // grown half sizes and centre offsets
    always_comb begin
        ew  = {1'b0, target_half_w} + {1'b0, mover_half_w};
        eh  = {1'b0, target_half_h} + {1'b0, mover_half_h};
        ewe = $signed({3'b000, ew});
        ehe = $signed({3'b000, eh});
        dx  = $signed({{3{target_x[COORD_BITS-1]}}, target_x})
            - $signed({{3{mover_x[COORD_BITS-1]}}, mover_x});
        dy  = $signed({{3{target_y[COORD_BITS-1]}}, target_y})
            - $signed({{3{mover_y[COORD_BITS-1]}}, mover_y});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_nx_reg <= dx - ewe;
            num_fx_reg <= dx + ewe;
            num_ny_reg <= dy - ehe;
            num_fy_reg <= dy + ehe;
            den_x_reg  <= $signed({mover_vx[COORD_BITS-1], mover_vx})
                        - $signed({target_vx[COORD_BITS-1], target_vx});
            den_y_reg  <= $signed({mover_vy[COORD_BITS-1], mover_vy})
                        - $signed({target_vy[COORD_BITS-1], target_vy});
        end
    end
endmodule
`default_nettype wire

// ===== src/saabb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saabb_div
// pipelined restoring divider, one quotient bit per stage, floor rounding
// ----------------------------------------------------------------------------
module saabb_div import saabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [COORD_BITS+2:0] num,
    input  wire logic signed [COORD_BITS:0]   den,
    output logic signed      [FRAC_BITS+2:0]  t_reg,
    output logic                              ok_reg
);
    localparam int NW = COORD_BITS + 3;
    localparam int DW = COORD_BITS + 1;
    localparam int QW = FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 3;
    localparam logic signed [TW-1:0] T_INF = TW'(1) << (FRAC_BITS + 1);

    logic [DW-1:0] d_reg   [0:FRAC_BITS];
    logic [DW-1:0] r_reg   [0:FRAC_BITS];
    logic [QW-1:0] q_reg   [0:FRAC_BITS];
    logic          sat_reg [0:FRAC_BITS];
    logic          neg_reg [0:FRAC_BITS];
    logic          okp_reg [0:FRAC_BITS];

    logic [NW-1:0] n, n_minus_d;
    logic [DW-1:0] d;
    logic          q0;

    // magnitudes, saturation and integer quotient bit
    always_comb begin
        n         = num[NW-1] ? $unsigned(-num) : $unsigned(num);
        d         = den[DW-1] ? $unsigned(-den) : $unsigned(den);
        q0        = n >= {2'b00, d};
        n_minus_d = n - {2'b00, d};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0]   <= d;
            r_reg[0]   <= q0 ? n_minus_d[DW-1:0] : n[DW-1:0];
            q_reg[0]   <= {{(QW-1){1'b0}}, q0};
            sat_reg[0] <= (d == '0) || (n >= {1'b0, d, 1'b0});
            neg_reg[0] <= (num != '0) && (num[NW-1] != den[DW-1]);
            okp_reg[0] <= (den != '0) || (num != '0);
        end
    end

    // fraction bit stages
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_bit
        logic [DW:0] r2, r2_sub;
        logic        ge;
        always_comb begin
            r2     = {r_reg[k-1], 1'b0};
            ge     = r2 >= {1'b0, d_reg[k-1]};
            r2_sub = r2 - {1'b0, d_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_reg[k-1];
                r_reg[k]   <= ge ? r2_sub[DW-1:0] : r2[DW-1:0];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                sat_reg[k] <= sat_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                okp_reg[k] <= okp_reg[k-1];
            end
        end
    end

    logic signed [TW-1:0] qs, t_next;

    // sign, floor correction and saturation
    always_comb begin
        qs = $signed({2'b00, q_reg[FRAC_BITS]});
        if (sat_reg[FRAC_BITS]) begin
            t_next = neg_reg[FRAC_BITS] ? -T_INF : T_INF;
        end else if (neg_reg[FRAC_BITS]) begin
            t_next = -(qs + ((r_reg[FRAC_BITS] != '0) ? TW'(1) : TW'(0)));
        end else begin
            t_next = qs;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg  <= t_next;
            ok_reg <= okp_reg[FRAC_BITS];
        end
    end
endmodule
`default_nettype wire

// ===== src/saabb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saabb_back
// slab ordering, overlap test, entry time and face normal
// ----------------------------------------------------------------------------
module saabb_back import saabb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic signed [FRAC_BITS+2:0] nx_in,
    input  wire logic signed [FRAC_BITS+2:0] fx_in,
    input  wire logic signed [FRAC_BITS+2:0] ny_in,
    input  wire logic signed [FRAC_BITS+2:0] fy_in,
    input  wire logic                        ok,
    input  wire logic                        vx_neg,
    input  wire logic                        vy_neg,
    output logic                             hit_reg,
    output logic             [FRAC_BITS:0]   entry_time_reg,
    output logic signed      [1:0]           normal_x_reg,
    output logic signed      [1:0]           normal_y_reg
);
    localparam int TW = FRAC_BITS + 3;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

    logic signed [TW-1:0] nx, fx, ny, fy, t;
    logic                 hit_next, x_face;

    always_comb begin
        nx = (nx_in > fx_in) ? fx_in : nx_in;
        fx = (nx_in > fx_in) ? nx_in : fx_in;
        ny = (ny_in > fy_in) ? fy_in : ny_in;
        fy = (ny_in > fy_in) ? ny_in : fy_in;
        x_face   = nx > ny;
        t        = x_face ? nx : ny;
        hit_next = ok && !(nx >= fy || ny >= fx) && !(t >= T_ONE) && !(t < 0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg        <= hit_next;
            entry_time_reg <= hit_next ? t[FRAC_BITS:0] : T_ONE[FRAC_BITS:0];
            normal_x_reg   <= (hit_next && x_face) ? (vx_neg ? 2'sd1 : -2'sd1) : 2'sd0;
            normal_y_reg   <= (hit_next && !x_face) ? (vy_neg ? 2'sd1 : -2'sd1) : 2'sd0;
        end
    end
endmodule
`default_nettype wire

// ===== src/swept_aabb_collision.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swept_aabb_collision
// swept box versus box contact test, fully pipelined
// ----------------------------------------------------------------------------
// Usage: present one box pair on the s_ channel with s_valid; it is taken
// when s_valid and s_ready are both high. The result (hit, entry time, face
// normal) appears on the m_ channel with m_valid and is taken on m_ready.
// One stage forms the slab numerators and relative velocity, four dividers
// run in parallel with one setup stage and one quotient bit per stage, one
// stage applies sign and floor rounding, and one stage orders the slabs and
// picks the face. Throughput is one request per cycle while the receiver
// does not stall; the divider bit stages set the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated. Reset clears the valid
// bits only, so the output channel comes up empty.
// ----------------------------------------------------------------------------
module swept_aabb_collision import saabb_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_mover_x,
    input  wire logic signed [COORD_BITS-1:0] s_mover_y,
    input  wire logic        [COORD_BITS-2:0] s_mover_half_w,
    input  wire logic        [COORD_BITS-2:0] s_mover_half_h,
    input  wire logic signed [COORD_BITS-1:0] s_mover_vx,
    input  wire logic signed [COORD_BITS-1:0] s_mover_vy,
    input  wire logic signed [COORD_BITS-1:0] s_target_x,
    input  wire logic signed [COORD_BITS-1:0] s_target_y,
    input  wire logic        [COORD_BITS-2:0] s_target_half_w,
    input  wire logic        [COORD_BITS-2:0] s_target_half_h,
    input  wire logic signed [COORD_BITS-1:0] s_target_vx,
    input  wire logic signed [COORD_BITS-1:0] s_target_vy,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic             [FRAC_BITS:0]    m_entry_time,
    output logic signed      [1:0]            m_normal_x,
    output logic signed      [1:0]            m_normal_y
);
    localparam int NW    = COORD_BITS + 3;
    localparam int DW    = COORD_BITS + 1;
    localparam int TW    = FRAC_BITS + 3;
    localparam int DEPTH = FRAC_BITS + 4;
    localparam int SIDE  = FRAC_BITS + 3;

    logic en;
    logic vld_reg [0:DEPTH-1];
    logic vxn_reg [0:SIDE-1];
    logic vyn_reg [0:SIDE-1];

    logic signed [NW-1:0] num_nx, num_fx, num_ny, num_fy;
    logic signed [DW-1:0] den_x, den_y;
    logic signed [TW-1:0] t_nx, t_fx, t_ny, t_fy;
    logic                 ok_nx, ok_fx, ok_ny, ok_fy;

    // pipeline advances unless a result waits for the receiver
    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // velocity signs ride along to the back stage
    always_ff @(posedge aclk) begin
        if (en) begin
            vxn_reg[0] <= (s_mover_vx < s_target_vx);
            vyn_reg[0] <= (s_mover_vy < s_target_vy);
            for (int i = 1; i < SIDE; i++) begin
                vxn_reg[i] <= vxn_reg[i-1];
                vyn_reg[i] <= vyn_reg[i-1];
            end
        end
    end

    saabb_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .en(en),
        .mover_x(s_mover_x), .mover_y(s_mover_y),
        .mover_half_w(s_mover_half_w), .mover_half_h(s_mover_half_h),
        .mover_vx(s_mover_vx), .mover_vy(s_mover_vy),
        .target_x(s_target_x), .target_y(s_target_y),
        .target_half_w(s_target_half_w), .target_half_h(s_target_half_h),
        .target_vx(s_target_vx), .target_vy(s_target_vy),
        .num_nx_reg(num_nx), .num_fx_reg(num_fx),
        .num_ny_reg(num_ny), .num_fy_reg(num_fy),
        .den_x_reg(den_x), .den_y_reg(den_y)
    );

    saabb_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_nx (
        .aclk(aclk), .en(en), .num(num_nx), .den(den_x), .t_reg(t_nx), .ok_reg(ok_nx));
    saabb_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_fx (
        .aclk(aclk), .en(en), .num(num_fx), .den(den_x), .t_reg(t_fx), .ok_reg(ok_fx));
    saabb_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_ny (
        .aclk(aclk), .en(en), .num(num_ny), .den(den_y), .t_reg(t_ny), .ok_reg(ok_ny));
    saabb_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_fy (
        .aclk(aclk), .en(en), .num(num_fy), .den(den_y), .t_reg(t_fy), .ok_reg(ok_fy));

    saabb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .en(en),
        .nx_in(t_nx), .fx_in(t_fx), .ny_in(t_ny), .fy_in(t_fy),
        .ok(ok_nx && ok_fx && ok_ny && ok_fy),
        .vx_neg(vxn_reg[SIDE-1]), .vy_neg(vyn_reg[SIDE-1]),
        .hit_reg(m_hit), .entry_time_reg(m_entry_time),
        .normal_x_reg(m_normal_x), .normal_y_reg(m_normal_y)
    );
endmodule
`default_nettype wire

// ===== src/saabb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saabb_checker
// port-level checks on the handshake and result channels, bound to the top level
// ----------------------------------------------------------------------------
module saabb_checker import saabb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic                    m_hit,
    input wire logic [FRAC_BITS:0]      m_entry_time,
    input wire logic signed [1:0]       m_normal_x,
    input wire logic signed [1:0]       m_normal_y
);
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // a stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request accepted while result stalled");

    // a miss reports time one and no normal
    a_miss_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_entry_time == ONE && m_normal_x == 2'sd0
                                 && m_normal_y == 2'sd0))
        else $error("miss result malformed");

    // a hit lies before one and names exactly one face
    a_hit_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_entry_time < ONE
                                && ((m_normal_x != 2'sd0) != (m_normal_y != 2'sd0))))
        else $error("hit result malformed");

    // output channel is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind swept_aabb_collision saabb_checker #(.FRAC_BITS(FRAC_BITS)) u_saabb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
    .m_entry_time(m_entry_time), .m_normal_x(m_normal_x), .m_normal_y(m_normal_y)
);
`default_nettype wire
